// ===== design/lswc_pkg.sv =====
`default_nettype none

package lswc_pkg;

  // Coordinate and datapath widths
  localparam int COORD_BITS = 16;
  localparam int DIFF_W     = COORD_BITS + 1;      // difference of two coordinates
  localparam int MAG_W      = COORD_BITS;          // magnitude of such a difference
  localparam int PROD_W     = 2 * MAG_W;           // product of two magnitudes
  localparam int SUM_W      = PROD_W + 2;          // base plus signed quotient
  localparam int DIV_CYCLES = PROD_W / 2;          // two quotient bits per cycle
  localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]     diff_t;
  typedef logic [MAG_W-1:0]             mag_t;
  typedef logic [PROD_W-1:0]            prod_t;
  typedef logic signed [SUM_W-1:0]      sum_t;

  // Region outcode bit positions
  localparam int CODE_LEFT   = 0;
  localparam int CODE_RIGHT  = 1;
  localparam int CODE_BOTTOM = 2;
  localparam int CODE_TOP    = 3;
  typedef logic [3:0] outcode_t;

  // Clipping step limit
  typedef logic [2:0] step_t;
  localparam step_t MAX_STEPS = 3'd4;

  // Configuration register indexes
  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t REG_WIN_X_LOW  = 2'd0;
  localparam cfg_idx_t REG_WIN_X_HIGH = 2'd1;
  localparam cfg_idx_t REG_WIN_Y_LOW  = 2'd2;
  localparam cfg_idx_t REG_WIN_Y_HIGH = 2'd3;

  localparam coord_t WIN_LOW_RESET  = COORD_BITS'(100);
  localparam coord_t WIN_HIGH_RESET = COORD_BITS'(300);

  localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  // Low edge is tested first, so an inverted window behaves consistently
  function automatic outcode_t outcode(input coord_t x, input coord_t y,
                                       input coord_t xl, input coord_t xh,
                                       input coord_t yl, input coord_t yh);
    outcode_t c;
    c = '0;
    if (x < xl) begin
      c[CODE_LEFT] = 1'b1;
    end else if (x > xh) begin
      c[CODE_RIGHT] = 1'b1;
    end
    if (y < yl) begin
      c[CODE_BOTTOM] = 1'b1;
    end else if (y > yh) begin
      c[CODE_TOP] = 1'b1;
    end
    return c;
  endfunction

  function automatic diff_t diff(input coord_t a, input coord_t b);
    return {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
  endfunction

  function automatic mag_t magnitude(input diff_t v);
    diff_t n;
    n = -v;
    return v[DIFF_W-1] ? n[MAG_W-1:0] : v[MAG_W-1:0];
  endfunction

  // Clamp to the signed coordinate range
  function automatic coord_t saturate(input sum_t v);
    logic [SUM_W-COORD_BITS:0] upper;
    upper = v[SUM_W-1:COORD_BITS-1];
    if ((&upper) || !(|upper)) begin
      return v[COORD_BITS-1:0];
    end
    return v[SUM_W-1] ? COORD_MIN : COORD_MAX;
  endfunction

endpackage

`default_nettype wire

// ===== design/line_segment_window_clipper.sv =====
// Each segment is checked in S_CHECK; each clipping step runs S_SETUP, S_MUL, S_DIV and
// S_FIX before the next check, at most four steps; S_DIV is skipped for a zero divisor.
// Segments are taken one at a time; the next is accepted once the result is loaded and the
// block is idle again, which waits while a stalled result still holds the output register.
// Each clipping step runs one multiply and, for a nonzero divisor, a radix-4 divide.
// Reset: rst is synchronous, active high; clears control, loads window edges 100 / 300.
`default_nettype none

module line_segment_window_clipper (
  input  wire logic                   clk,
  input  wire logic                   rst,
  // configuration write port
  input  wire logic                   cfg_write,
  input  wire lswc_pkg::cfg_idx_t     cfg_index,
  input  wire lswc_pkg::coord_t       cfg_data,
  // segment channel
  input  wire logic                   seg_valid,
  output logic                        seg_stall,
  input  wire logic [15:0]            segment_tag,
  input  wire lswc_pkg::coord_t       ax,
  input  wire lswc_pkg::coord_t       ay,
  input  wire lswc_pkg::coord_t       bx,
  input  wire lswc_pkg::coord_t       by,
  // result channel
  output logic                        res_valid,
  input  wire logic                   res_stall,
  output logic [15:0]                 tag_out,
  output logic                        visible,
  output lswc_pkg::coord_t            clip_ax,
  output lswc_pkg::coord_t            clip_ay,
  output lswc_pkg::coord_t            clip_bx,
  output lswc_pkg::coord_t            clip_by
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CHECK = 7'b0000010,   // outcodes, trivial accept/reject, step limit, pick an edge
    S_SETUP = 7'b0000100,   // operand magnitudes, sign and base
    S_MUL   = 7'b0001000,   // shared multiplier
    S_DIV   = 7'b0010000,   // shared divider, two quotient bits per cycle
    S_FIX   = 7'b0100000,   // apply sign, add base, saturate, replace endpoint
    S_DONE  = 7'b1000000    // wait for the output register
  } state_t;

  state_t state;

  // Window edges
  lswc_pkg::coord_t win_x_low, win_x_high, win_y_low, win_y_high;

  // Segment under work: original endpoints and current clipped endpoints
  logic [15:0]      seg_tag;
  lswc_pkg::coord_t seg_ax, seg_ay, seg_bx, seg_by;
  lswc_pkg::coord_t px, py, qx, qy;
  lswc_pkg::step_t  step;
  logic             acc;

  // Clip step context
  logic             sel_a;     // replacing endpoint A
  logic             clip_y;    // horizontal edge: solve for x
  lswc_pkg::coord_t edge_val;
  lswc_pkg::mag_t   n1_mag, n2_mag, d_mag;
  logic             neg;
  lswc_pkg::coord_t base;

  // Divider
  lswc_pkg::prod_t              dvd, quo;
  lswc_pkg::mag_t               rem;
  logic [lswc_pkg::DIV_CNT_W-1:0] div_cnt;

  // Result handoff: load the output register when it is free or being emptied
  logic res_load;

  // ---------------------------------------------------------------------------
  // Outcode evaluation and edge selection
  // ---------------------------------------------------------------------------
  lswc_pkg::outcode_t c1, c2, co;

  always_comb begin
    c1 = lswc_pkg::outcode(px, py, win_x_low, win_x_high, win_y_low, win_y_high);
    c2 = lswc_pkg::outcode(qx, qy, win_x_low, win_x_high, win_y_low, win_y_high);
    co = (c1 != '0) ? c1 : c2;
  end

  // ---------------------------------------------------------------------------
  // Operand setup: for a horizontal edge x = ax + (bx-ax)(edge-ay)/(by-ay),
  // for a vertical edge y = ay + (by-ay)(edge-ax)/(bx-ax)
  // ---------------------------------------------------------------------------
  lswc_pkg::diff_t dx, dy, n2_s, n1_s, d_s;

  always_comb begin
    dx   = lswc_pkg::diff(seg_bx, seg_ax);
    dy   = lswc_pkg::diff(seg_by, seg_ay);
    n1_s = clip_y ? dx : dy;
    d_s  = clip_y ? dy : dx;
    n2_s = clip_y ? lswc_pkg::diff(edge_val, seg_ay) : lswc_pkg::diff(edge_val, seg_ax);
  end

  // ---------------------------------------------------------------------------
  // Radix-4 restoring divide step on magnitudes
  // ---------------------------------------------------------------------------
  logic [lswc_pkg::MAG_W:0] r1, r2;
  lswc_pkg::mag_t           rem1, rem_next;
  logic                     qb1, qb0;

  always_comb begin
    r1   = {rem, dvd[lswc_pkg::PROD_W-1]};
    qb1  = (r1 >= {1'b0, d_mag});
    rem1 = qb1 ? lswc_pkg::MAG_W'(r1 - {1'b0, d_mag}) : r1[lswc_pkg::MAG_W-1:0];
    r2   = {rem1, dvd[lswc_pkg::PROD_W-2]};
    qb0  = (r2 >= {1'b0, d_mag});
    rem_next = qb0 ? lswc_pkg::MAG_W'(r2 - {1'b0, d_mag}) : r2[lswc_pkg::MAG_W-1:0];
  end

  // ---------------------------------------------------------------------------
  // Intersection: sign the quotient, add the base coordinate, saturate
  // ---------------------------------------------------------------------------
  lswc_pkg::sum_t   q_ext, q_signed, sum;
  lswc_pkg::coord_t isect;

  always_comb begin
    q_ext    = lswc_pkg::SUM_W'(quo);
    q_signed = neg ? -q_ext : q_ext;
    sum      = lswc_pkg::SUM_W'(base) + q_signed;
    isect    = lswc_pkg::saturate(sum);
  end

  // hold off new segments while busy and during reset
  assign seg_stall = rst || (state != S_IDLE);
  assign res_load  = (state == S_DONE) && (!res_valid || !res_stall);

  // ---------------------------------------------------------------------------
  // Control: sequencer, window registers, step count, result handshake
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      res_valid  <= 1'b0;
      step       <= '0;
      div_cnt    <= '0;
      win_x_low  <= lswc_pkg::WIN_LOW_RESET;
      win_x_high <= lswc_pkg::WIN_HIGH_RESET;
      win_y_low  <= lswc_pkg::WIN_LOW_RESET;
      win_y_high <= lswc_pkg::WIN_HIGH_RESET;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          lswc_pkg::REG_WIN_X_LOW:  win_x_low  <= cfg_data;
          lswc_pkg::REG_WIN_X_HIGH: win_x_high <= cfg_data;
          lswc_pkg::REG_WIN_Y_LOW:  win_y_low  <= cfg_data;
          lswc_pkg::REG_WIN_Y_HIGH: win_y_high <= cfg_data;
          default: ;
        endcase
      end

      // raise the result when loaded, drop it once the consumer takes it
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (seg_valid) begin
            step  <= '0;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if ((c1 == '0) && (c2 == '0)) begin
            state <= S_DONE;
          end else if (((c1 & c2) != '0) || (step == lswc_pkg::MAX_STEPS)) begin
            state <= S_DONE;
          end else begin
            state <= S_SETUP;
          end
        end
        S_SETUP: begin
          state <= S_MUL;
        end
        S_MUL: begin
          // a zero divisor takes a zero quotient: skip the divide
          if (d_mag == '0) begin
            state <= S_FIX;
          end else begin
            div_cnt <= lswc_pkg::DIV_CNT_W'(lswc_pkg::DIV_CYCLES - 1);
            state   <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_cnt == '0) begin
            state <= S_FIX;
          end else begin
            div_cnt <= div_cnt - 1'b1;
          end
        end
        S_FIX: begin
          step  <= step + 1'b1;
          state <= S_CHECK;
        end
        S_DONE: begin
          // hold until the output register is free
          if (res_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (seg_valid) begin
          seg_tag <= segment_tag;
          seg_ax  <= ax;
          seg_ay  <= ay;
          seg_bx  <= bx;
          seg_by  <= by;
          px      <= ax;
          py      <= ay;
          qx      <= bx;
          qy      <= by;
        end
      end
      S_CHECK: begin
        acc   <= (c1 == '0) && (c2 == '0);
        sel_a <= (c1 != '0);
        // edge order: top, bottom, right, left
        if (co[lswc_pkg::CODE_TOP]) begin
          clip_y   <= 1'b1;
          edge_val <= win_y_high;
        end else if (co[lswc_pkg::CODE_BOTTOM]) begin
          clip_y   <= 1'b1;
          edge_val <= win_y_low;
        end else if (co[lswc_pkg::CODE_RIGHT]) begin
          clip_y   <= 1'b0;
          edge_val <= win_x_high;
        end else begin
          clip_y   <= 1'b0;
          edge_val <= win_x_low;
        end
      end
      S_SETUP: begin
        n1_mag <= lswc_pkg::magnitude(n1_s);
        n2_mag <= lswc_pkg::magnitude(n2_s);
        d_mag  <= lswc_pkg::magnitude(d_s);
        neg    <= n1_s[lswc_pkg::DIFF_W-1] ^ n2_s[lswc_pkg::DIFF_W-1] ^
                  d_s[lswc_pkg::DIFF_W-1];
        base   <= clip_y ? seg_ax : seg_ay;
      end
      S_MUL: begin
        dvd <= lswc_pkg::PROD_W'(n1_mag * n2_mag);
        rem <= '0;
        quo <= '0;
      end
      S_DIV: begin
        dvd <= {dvd[lswc_pkg::PROD_W-3:0], 2'b00};
        rem <= rem_next;
        quo <= {quo[lswc_pkg::PROD_W-3:0], qb1, qb0};
      end
      S_FIX: begin
        if (sel_a) begin
          px <= clip_y ? isect : edge_val;
          py <= clip_y ? edge_val : isect;
        end else begin
          qx <= clip_y ? isect : edge_val;
          qy <= clip_y ? edge_val : isect;
        end
      end
      S_DONE: begin
        if (res_load) begin
          tag_out <= seg_tag;
          visible <= acc;
          clip_ax <= acc ? px : '0;
          clip_ay <= acc ? py : '0;
          clip_bx <= acc ? qx : '0;
          clip_by <= acc ? qy : '0;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire
